// ----- hw/rtl/qcos_pkg.sv -----
// Shared widths, constants and types for the quad corner cosine score block.
`timescale 1ns / 1ps
`default_nettype none
package qcos_pkg;
   localparam int COORD_BITS        = 24;
   localparam int FRAC_BITS         = 15;
   localparam int NUM_CORNERS       = 4;
   localparam int NUM_FIELDS        = 3 * NUM_CORNERS;
   localparam int REQ_DATA_BITS     = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
   localparam int EDGE_BITS         = COORD_BITS + 1;
   localparam int HALF_BITS         = EDGE_BITS;
   localparam int LEN_BITS          = 2 * EDGE_BITS;
   localparam int PROD_BITS         = 2 * LEN_BITS;
   localparam int REF_BITS          = PROD_BITS + 2 * FRAC_BITS;
   localparam int CAND_BITS         = REF_BITS + 2;
   localparam int SP_BITS           = PROD_BITS + FRAC_BITS + 1;
   localparam int SCORE_BITS        = FRAC_BITS + 1;
   localparam int STEPS             = FRAC_BITS + 1;
   localparam int LANE_STAGES       = 4 + STEPS;
   localparam int NUM_STAGES        = LANE_STAGES + 3;
   localparam int SCORE_FIELD_BITS  = 16;
   localparam int THRESH_BITS       = 16;
   localparam int RSP_USER_BITS     = 2;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd23170;

   typedef logic signed [EDGE_BITS-1:0] edge_type;

   typedef struct packed {
      edge_type x;
      edge_type y;
      edge_type z;
   } vec_type;
endpackage
`default_nettype wire

// ----- hw/rtl/qcos_lane.sv -----
// One corner lane: squared lengths, dot product and the bit-by-bit exact score.
`timescale 1ns / 1ps
`default_nettype none
module qcos_lane
   import qcos_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [LANE_STAGES-1:0] en,
   input  wire vec_type                a_in,
   input  wire vec_type                b_in,
   output logic [SCORE_BITS-1:0]       score,
   output logic                        degen
);
   // stage 0: nine products
   logic signed [LEN_BITS-1:0] aa_ff [3];
   logic signed [LEN_BITS-1:0] bb_ff [3];
   logic signed [LEN_BITS-1:0] ab_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         aa_ff[0] <= a_in.x * a_in.x;
         aa_ff[1] <= a_in.y * a_in.y;
         aa_ff[2] <= a_in.z * a_in.z;
         bb_ff[0] <= b_in.x * b_in.x;
         bb_ff[1] <= b_in.y * b_in.y;
         bb_ff[2] <= b_in.z * b_in.z;
         ab_ff[0] <= a_in.x * b_in.x;
         ab_ff[1] <= a_in.y * b_in.y;
         ab_ff[2] <= a_in.z * b_in.z;
      end
   end

   // stage 1: sums, |a.b|, zero-length test
   logic signed [LEN_BITS+1:0] la_sum, lb_sum, dot_sum, dot_abs;
   logic [LEN_BITS-1:0] la_ff, lb_ff, d_ff;
   logic                degen1_ff;

   assign la_sum  = (LEN_BITS+2)'(aa_ff[0]) + (LEN_BITS+2)'(aa_ff[1])
                  + (LEN_BITS+2)'(aa_ff[2]);
   assign lb_sum  = (LEN_BITS+2)'(bb_ff[0]) + (LEN_BITS+2)'(bb_ff[1])
                  + (LEN_BITS+2)'(bb_ff[2]);
   assign dot_sum = (LEN_BITS+2)'(ab_ff[0]) + (LEN_BITS+2)'(ab_ff[1])
                  + (LEN_BITS+2)'(ab_ff[2]);
   assign dot_abs = dot_sum[LEN_BITS+1] ? -dot_sum : dot_sum;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         la_ff     <= la_sum[LEN_BITS-1:0];
         lb_ff     <= lb_sum[LEN_BITS-1:0];
         d_ff      <= dot_abs[LEN_BITS-1:0];
         degen1_ff <= (la_sum == '0) || (lb_sum == '0);
      end
   end

   // stage 2: half-width partial products
   logic [LEN_BITS-1:0] phh_ff, phl_ff, plh_ff, pll_ff, dhh_ff, dhl_ff, dll_ff;
   logic                degen2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         phh_ff    <= la_ff[LEN_BITS-1:HALF_BITS] * lb_ff[LEN_BITS-1:HALF_BITS];
         phl_ff    <= la_ff[LEN_BITS-1:HALF_BITS] * lb_ff[HALF_BITS-1:0];
         plh_ff    <= la_ff[HALF_BITS-1:0] * lb_ff[LEN_BITS-1:HALF_BITS];
         pll_ff    <= la_ff[HALF_BITS-1:0] * lb_ff[HALF_BITS-1:0];
         dhh_ff    <= d_ff[LEN_BITS-1:HALF_BITS] * d_ff[LEN_BITS-1:HALF_BITS];
         dhl_ff    <= d_ff[LEN_BITS-1:HALF_BITS] * d_ff[HALF_BITS-1:0];
         dll_ff    <= d_ff[HALF_BITS-1:0] * d_ff[HALF_BITS-1:0];
         degen2_ff <= degen1_ff;
      end
   end

   // stage 3: P = |a|^2 |b|^2, R = (a.b)^2 * 2^2F
   logic [PROD_BITS-1:0] p_sum, d2_sum, p_ff;
   logic [REF_BITS-1:0]  r_ff;
   logic                 degen3_ff;

   assign p_sum  = (PROD_BITS'(phh_ff) << LEN_BITS) + (PROD_BITS'(phl_ff) << HALF_BITS)
                 + (PROD_BITS'(plh_ff) << HALF_BITS) + PROD_BITS'(pll_ff);
   assign d2_sum = (PROD_BITS'(dhh_ff) << LEN_BITS) + (PROD_BITS'(dhl_ff) << (HALF_BITS + 1))
                 + PROD_BITS'(dll_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         p_ff      <= p_sum;
         r_ff      <= REF_BITS'(d2_sum) << (2 * FRAC_BITS);
         degen3_ff <= degen2_ff;
      end
   end

   // one score bit per stage, MSB first; s*P and s^2*P kept incrementally
   logic [SCORE_BITS-1:0] s_ff   [STEPS];
   logic [SP_BITS-1:0]    sp_ff  [STEPS];
   logic [REF_BITS-1:0]   s2p_ff [STEPS];
   logic [PROD_BITS-1:0]  pp_ff  [STEPS];
   logic [REF_BITS-1:0]   rr_ff  [STEPS];
   logic                  dg_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int BIT = FRAC_BITS - k;
      logic [SCORE_BITS-1:0] s_prev;
      logic [SP_BITS-1:0]    sp_prev;
      logic [REF_BITS-1:0]   s2p_prev, r_prev;
      logic [PROD_BITS-1:0]  p_prev;
      logic                  dg_prev, take;
      logic [CAND_BITS-1:0]  cand;

      if (k == 0) begin : g_first
         assign s_prev   = '0;
         assign sp_prev  = '0;
         assign s2p_prev = '0;
         assign p_prev   = p_ff;
         assign r_prev   = r_ff;
         assign dg_prev  = degen3_ff;
      end else begin : g_next
         assign s_prev   = s_ff[k-1];
         assign sp_prev  = sp_ff[k-1];
         assign s2p_prev = s2p_ff[k-1];
         assign p_prev   = pp_ff[k-1];
         assign r_prev   = rr_ff[k-1];
         assign dg_prev  = dg_ff[k-1];
      end

      assign cand = CAND_BITS'(s2p_prev) + (CAND_BITS'(sp_prev) << (BIT + 1))
                  + (CAND_BITS'(p_prev) << (2 * BIT));
      assign take = cand <= CAND_BITS'(r_prev);

      always_ff @(posedge clock) begin
         if (en[4+k]) begin
            s_ff[k]   <= take ? (s_prev | (SCORE_BITS'(1) << BIT)) : s_prev;
            sp_ff[k]  <= take ? (sp_prev + (SP_BITS'(p_prev) << BIT)) : sp_prev;
            s2p_ff[k] <= take ? cand[REF_BITS-1:0] : s2p_prev;
            pp_ff[k]  <= p_prev;
            rr_ff[k]  <= r_prev;
            dg_ff[k]  <= dg_prev;
         end
      end
   end

   assign score = s_ff[STEPS-1];
   assign degen = dg_ff[STEPS-1];
endmodule
`default_nettype wire

// ----- hw/rtl/qcos_merge.sv -----
// Merge stage: largest corner score, degenerate override, threshold compare.
`timescale 1ns / 1ps
`default_nettype none
module qcos_merge
   import qcos_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [SCORE_BITS-1:0]       score [NUM_CORNERS],
   input  wire logic [NUM_CORNERS-1:0]      degen,
   input  wire logic [THRESH_BITS-1:0]      threshold,
   output logic [SCORE_FIELD_BITS-1:0]      max_abs_cosine,
   output logic                             accepted,
   output logic                             degenerate
);
   logic [SCORE_BITS-1:0]                  m01, m23, best, sel;
   logic [SCORE_BITS+SCORE_FIELD_BITS-1:0] wide;
   logic [SCORE_FIELD_BITS-1:0]            field;
   logic [SCORE_FIELD_BITS-1:0]            score_ff;
   logic                                   acc_ff, degen_ff;

   assign m01   = (score[0] > score[1]) ? score[0] : score[1];
   assign m23   = (score[2] > score[3]) ? score[2] : score[3];
   assign best  = (m01 > m23) ? m01 : m23;
   assign sel   = (|degen) ? (SCORE_BITS'(1) << FRAC_BITS) : best;
   assign wide  = {{SCORE_FIELD_BITS{1'b0}}, sel};
   assign field = wide[SCORE_FIELD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         score_ff <= field;
         acc_ff   <= field < threshold;
         degen_ff <= |degen;
      end
   end

   assign max_abs_cosine = score_ff;
   assign accepted       = acc_ff;
   assign degenerate     = degen_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/quad_corner_orthogonality_score_core.sv -----
// Top level: input register, edge vectors, four corner lanes, merge and output word.
// Pipeline: 23 register stages (input reg, edges, 20 lane stages, merge/output reg);
// one word per cycle sustained while rsp_tready stays high.
// Full rate holds because each of the 16 score bits has its own pipeline stage.
// Each stage advances when it is empty or its successor advances, so bubbles fill.
// Synchronous active-high reset clears valid bits; threshold resets to 23170.
`timescale 1ns / 1ps
`default_nettype none
module quad_corner_orthogonality_score_core
   import qcos_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // corner0_x, corner0_y, corner0_z, corner1_x, ... corner3_z
   input  wire logic [REQ_DATA_BITS-1:0]      req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // max_abs_cosine
   output logic [SCORE_FIELD_BITS-1:0]        rsp_tdata,
   // accepted, degenerate
   output logic [RSP_USER_BITS-1:0]           rsp_tuser,
   input  wire logic                          csr_wr_en,
   input  wire logic [THRESH_BITS-1:0]        csr_wr_data
);
   logic [THRESH_BITS-1:0] thresh_ff;
   logic [NUM_STAGES-1:0]  valid_ff, valid_in, adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   logic [REQ_DATA_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         data_ff <= req_tdata;
      end
   end

   // edge vectors to the previous and next corner
   edge_type pt_x [NUM_CORNERS];
   edge_type pt_y [NUM_CORNERS];
   edge_type pt_z [NUM_CORNERS];
   vec_type  a_ff [NUM_CORNERS];
   vec_type  b_ff [NUM_CORNERS];

   logic [SCORE_BITS-1:0]  lane_score [NUM_CORNERS];
   logic [NUM_CORNERS-1:0] lane_degen;

   for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_corner
      localparam int PV = (i + NUM_CORNERS - 1) % NUM_CORNERS;
      localparam int NX = (i + 1) % NUM_CORNERS;

      assign pt_x[i] = EDGE_BITS'($signed(data_ff[(3*i+0)*COORD_BITS +: COORD_BITS]));
      assign pt_y[i] = EDGE_BITS'($signed(data_ff[(3*i+1)*COORD_BITS +: COORD_BITS]));
      assign pt_z[i] = EDGE_BITS'($signed(data_ff[(3*i+2)*COORD_BITS +: COORD_BITS]));

      always_ff @(posedge clock) begin
         if (adv[1]) begin
            a_ff[i].x <= pt_x[PV] - pt_x[i];
            a_ff[i].y <= pt_y[PV] - pt_y[i];
            a_ff[i].z <= pt_z[PV] - pt_z[i];
            b_ff[i].x <= pt_x[NX] - pt_x[i];
            b_ff[i].y <= pt_y[NX] - pt_y[i];
            b_ff[i].z <= pt_z[NX] - pt_z[i];
         end
      end

      qcos_lane u_lane (
         .clock (clock),
         .en    (adv[LANE_STAGES+1:2]),
         .a_in  (a_ff[i]),
         .b_in  (b_ff[i]),
         .score (lane_score[i]),
         .degen (lane_degen[i])
      );
   end

   qcos_merge u_merge (
      .clock          (clock),
      .en             (adv[NUM_STAGES-1]),
      .score          (lane_score),
      .degen          (lane_degen),
      .threshold      (thresh_ff),
      .max_abs_cosine (rsp_tdata),
      .accepted       (rsp_tuser[0]),
      .degenerate     (rsp_tuser[1])
   );
endmodule
`default_nettype wire

// ----- bench/quad_corner_orthogonality_score_core_test.sv -----
// Self-checking bench for the quad corner cosine score core: driver, monitor, exact predictor.
`timescale 1ns / 1ps
`default_nettype none
module quad_corner_orthogonality_score_core_test;
   import qcos_pkg::*;

   typedef struct packed {
      logic [15:0] score;
      logic        accepted;
      logic        degenerate;
   } verdict_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SCORE_FIELD_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [THRESH_BITS-1:0] csr_wr_data = '0;

   quad_corner_orthogonality_score_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [REQ_DATA_BITS-1:0] quad_queue[$];
   verdict_type              verdict_queue[$];
   logic [15:0]              threshold = THRESH_RESET;
   int errors = 0;
   int quads_sent = 0;
   int quads_scored = 0;
   int degenerate_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit hold_sender = 1'b0;
   bit stall_mode = 1'b0;

   // floor(2^15 * |d| / sqrt(la*lb)) by exact bitwise search
   function automatic logic [15:0] corner_cosine(input logic signed [EDGE_BITS-1:0] a[3],
                                                 input logic signed [EDGE_BITS-1:0] b[3],
                                                 output bit zero_edge);
      logic [127:0] la, lb, prod;
      logic signed [127:0] dot;
      logic [255:0] lhs, rhs;
      logic [16:0] s, t;
      la = 0; lb = 0; dot = 0; s = 0;
      for (int k = 0; k < 3; k++) begin
         la  += 128'(a[k]) * 128'(a[k]);
         lb  += 128'(b[k]) * 128'(b[k]);
         dot += 128'(signed'(a[k])) * 128'(signed'(b[k]));
      end
      zero_edge = (la == 0) || (lb == 0);
      if (zero_edge) return 16'd0;
      if (dot < 0) dot = -dot;
      rhs  = (256'(dot) * 256'(dot)) << (2 * FRAC_BITS);
      prod = la * lb;
      for (int bitpos = FRAC_BITS; bitpos >= 0; bitpos--) begin
         t = s | (17'd1 << bitpos);
         if (t <= (17'd1 << FRAC_BITS)) begin
            lhs = 256'(prod) * 256'(t) * 256'(t);
            if (lhs <= rhs) s = t;
         end
      end
      return s[15:0];
   endfunction

   function automatic verdict_type score_quad(input logic [REQ_DATA_BITS-1:0] word);
      logic signed [EDGE_BITS-1:0] pt[4][3];
      logic signed [EDGE_BITS-1:0] a[3], b[3];
      logic [15:0] best, sc;
      bit zero_edge, degen;
      verdict_type v;
      best = 0; degen = 0;
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++)
            pt[i][k] = coord_type'(word[(i*3+k)*COORD_BITS +: COORD_BITS]);
      for (int i = 0; i < 4; i++) begin
         if (!degen) begin
            for (int k = 0; k < 3; k++) begin
               a[k] = pt[(i+3)%4][k] - pt[i][k];
               b[k] = pt[(i+1)%4][k] - pt[i][k];
            end
            sc = corner_cosine(a, b, zero_edge);
            if (zero_edge) degen = 1;
            else if (sc > best) best = sc;
         end
      end
      if (degen) best = 16'd32768;
      v.score = best;
      v.accepted = best < threshold;
      v.degenerate = degen;
      return v;
   endfunction

   function automatic logic [REQ_DATA_BITS-1:0] pack_quad(input coord_type c[12]);
      logic [REQ_DATA_BITS-1:0] w;
      w = '0;
      for (int i = 0; i < 12; i++) w[i*COORD_BITS +: COORD_BITS] = c[i];
      return w;
   endfunction

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 64)) - 32);
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return coord_type'(int'($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   // driver: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) quads_sent++;
         if (req_tvalid && req_tready) verdict_queue = {verdict_queue, score_quad(req_tdata)};
         if (gap_left > 0) gap_left--;
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         end
         if (quad_queue.size() > 0 && !hold_sender && (burst_left > 0 || gap_left == 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= quad_queue.pop_front();
            if (burst_left > 0) burst_left--;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor with receiver stall pattern
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         quads_scored++;
         if (verdict_queue.size() == 0) begin
            $error("result word with no expected quad");
            errors++;
         end else begin
            want = verdict_queue.pop_front();
            if (want.degenerate) degenerate_seen++;
            if (rsp_tdata !== want.score) begin
               $error("max_abs_cosine exp %0d got %0d", want.score, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== want.accepted) begin
               $error("accepted exp %0d got %0d", want.accepted, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== want.degenerate) begin
               $error("degenerate exp %0d got %0d", want.degenerate, rsp_tuser[1]);
               errors++;
            end
         end
      end
      if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
   end

   // wait until every queued quad is sent and every result is back, then idle a while
   task automatic drain_and_idle();
      while (quad_queue.size() > 0 || req_tvalid || verdict_queue.size() > 0)
         @(negedge clock);
      hold_sender = 1'b1;
      repeat (NUM_STAGES + 5) @(posedge clock);
      hold_sender = 1'b0;
   endtask

   task automatic write_threshold(input logic [15:0] value);
      drain_and_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      threshold = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_random_quads(input int count);
      coord_type c[12];
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 12; i++) c[i] = rand_coord(mode);
         // sometimes make neighbors coincide
         if ($urandom_range(0, 15) == 0) begin
            int j = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++) c[((j+1)%4)*3+k] = c[j*3+k];
         end
         // sometimes an axis-aligned rectangle in the z = 0 plane
         if ($urandom_range(0, 7) == 0) begin
            coord_type w = rand_coord(3), h = rand_coord(3);
            for (int k = 0; k < 12; k++) c[k] = 0;
            c[3] = w; c[6] = w; c[7] = h; c[10] = h;
         end
         quad_queue = {quad_queue, pack_quad(c)};
      end
   endtask

   initial begin
      coord_type c[12];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: square of side 100, extremes, degenerate, collinear, skew
      foreach (c[i]) c[i] = 0;
      c[3] = 100; c[6] = 100; c[7] = 100; c[10] = 100;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = 24'sh7FFFFF;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = (i % 2) ? 24'sh800000 : 24'sh7FFFFF;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = ((i / 3) % 2) ? 24'sh800000 : 24'sh7FFFFF;
      c[4] = 24'sh7FFFFF; c[11] = 24'sh800000;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = 0;
      c[3] = 1; c[6] = 2; c[9] = 3;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = 0;
      c[3] = 24'sh7FFFFF; c[6] = 24'sh7FFFFF; c[7] = 24'sh800000; c[11] = 24'sh800000;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = 0;
      c[3] = 5; c[4] = 1; c[6] = 5; c[7] = 7; c[8] = -3; c[10] = 4;
      quad_queue = {quad_queue, pack_quad(c)};
      foreach (c[i]) c[i] = 24'sh800000;
      c[9] = 24'sh7FFFFF; c[10] = 0;
      quad_queue = {quad_queue, pack_quad(c)};
      add_random_quads(12);

      write_threshold(16'd32768);
      add_random_quads(400);
      write_threshold(16'hFFFF);
      add_random_quads(300);
      write_threshold(16'd0);
      add_random_quads(300);
      write_threshold(16'd30000);
      add_random_quads(400);
      write_threshold(16'($urandom_range(1, 32767)));
      add_random_quads(400);

      drain_and_idle();
      $display("Sent %0d quads, scored %0d (%0d degenerate) over six threshold settings.",
               quads_sent, quads_scored, degenerate_seen);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
